[rtl/battery_voltage_temp_adc_converter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the battery voltage and temperature converter
// Shared wrappers for concurrent assertions on the aclk domain.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_TEMP_ADC_CONVERTER_MACROS_SVH
`define BATTERY_VOLTAGE_TEMP_ADC_CONVERTER_MACROS_SVH

// Checked only outside reset.
`define BVTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define BVTC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/bvtc_pkg.sv]
// ----------------------------------------------------------------------------
// bvtc_pkg
// Types, constants and coefficient tables for the battery voltage and
// temperature converter.
// ----------------------------------------------------------------------------
package bvtc_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int SEGMENT_BITS = 6;
    localparam int SEGMENTS     = 16;
    localparam int SEG_IDX_BITS = SAMPLE_BITS - SEGMENT_BITS;

    localparam int MV_W   = 13;
    localparam int CHG_W  = 8;
    localparam int TEMP_W = 9;

    // Millivolts are sample * 1525 / 281, the reduced form of 7625 / 1405.
    localparam int VOLT_MUL    = 1525;
    localparam int VOLT_RECIP  = 1910573;
    localparam int VOLT_SHIFT  = 29;
    localparam int VPROD_W     = 21;
    localparam int VRECIP_W    = 21;
    localparam int VQ_W        = VPROD_W + VRECIP_W;

    localparam int SOC_BASE_MV = 3000;
    localparam int SOC_RECIP   = 2731;
    localparam int SOC_SHIFT   = 15;
    localparam int SOC_DIFF_W  = 12;
    localparam int SOC_RECIP_W = 12;
    localparam int SOC_PROD_W  = SOC_DIFF_W + SOC_RECIP_W;
    localparam int SOC_Q_W     = SOC_PROD_W - SOC_SHIFT;

    localparam int FRAC_BITS = 10;
    localparam int BASE_W    = 19;
    localparam int SLOPE_W   = 11;
    localparam int SPROD_W   = SLOPE_W + SEGMENT_BITS + 1;
    localparam int ACC_W     = 20;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic    is_temp;
        logic    mux_next;
        sample_t sample;
    } item_t;

    function automatic logic signed [BASE_W-1:0] seg_base(input logic [SEG_IDX_BITS-1:0] idx);
        logic signed [BASE_W-1:0] v;
        case (idx)
            4'd0:    v = 19'sd184320;
            4'd1:    v = 19'sd141626;
            4'd2:    v = 19'sd106309;
            4'd3:    v = 19'sd87178;
            4'd4:    v = 19'sd73914;
            4'd5:    v = 19'sd63602;
            4'd6:    v = 19'sd55016;
            4'd7:    v = 19'sd47525;
            4'd8:    v = 19'sd40752;
            4'd9:    v = 19'sd34449;
            4'd10:   v = 19'sd28431;
            4'd11:   v = 19'sd22547;
            4'd12:   v = 19'sd16652;
            4'd13:   v = 19'sd10591;
            4'd14:   v = 19'sd4159;
            default: v = -19'sd2948;
        endcase
        return v;
    endfunction

    function automatic logic signed [SLOPE_W-1:0] seg_slope(input logic [SEG_IDX_BITS-1:0] idx);
        logic signed [SLOPE_W-1:0] v;
        case (idx)
            4'd0:    v = -11'sd800;
            4'd1:    v = -11'sd552;
            4'd2:    v = -11'sd299;
            4'd3:    v = -11'sd207;
            4'd4:    v = -11'sd161;
            4'd5:    v = -11'sd134;
            4'd6:    v = -11'sd117;
            4'd7:    v = -11'sd106;
            4'd8:    v = -11'sd98;
            4'd9:    v = -11'sd94;
            4'd10:   v = -11'sd92;
            4'd11:   v = -11'sd92;
            4'd12:   v = -11'sd95;
            4'd13:   v = -11'sd101;
            4'd14:   v = -11'sd111;
            default: v = 11'sd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/battery_voltage_temp_adc_converter.sv]
// ----------------------------------------------------------------------------
// battery_voltage_temp_adc_converter
// Converts alternating battery and thermistor ADC samples into held
// millivolt, charge and temperature readings.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result word, one sample per clock cycle
// sustained while m_ready keeps the pipeline advancing, passing through
// the three conversion stages (voltage multiply, reciprocal division and
// segment interpolation, then the charge divide). A two-entry queue sits in
// front of the pipeline, so s_ready stays high for up to two more samples
// while a finished word waits, and then drops until m_ready takes the word.
// The mux level starts at 0 and toggles with every sample; a sample is
// treated as battery voltage when that level equals the cfg_data register.
module battery_voltage_temp_adc_converter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bvtc_pkg::SAMPLE_BITS-1:0]    s_raw_sample,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_channel_read,
    output logic                                m_mux_next,
    output logic [bvtc_pkg::MV_W-1:0]           m_voltage_mv,
    output logic [bvtc_pkg::CHG_W-1:0]          m_charge_percent,
    output logic signed [bvtc_pkg::TEMP_W-1:0]  m_temperature_deg
);
    import bvtc_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    item_t q_push_data;
    item_t q_pop_data;

    bvtc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_raw_sample (s_raw_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_data  (q_push_data)
    );

    bvtc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    bvtc_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_data            (q_pop_data),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_channel_read    (m_channel_read),
        .m_mux_next        (m_mux_next),
        .m_voltage_mv      (m_voltage_mv),
        .m_charge_percent  (m_charge_percent),
        .m_temperature_deg (m_temperature_deg)
    );

endmodule

[rtl/bvtc_front.sv]
// ----------------------------------------------------------------------------
// bvtc_front
// Accepts samples, tags each one with the channel it came from and the next
// mux level, and holds the channel select register.
// ----------------------------------------------------------------------------
module bvtc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [bvtc_pkg::SAMPLE_BITS-1:0] s_raw_sample,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data,
    input  logic                      q_full,
    output logic                      q_push,
    output bvtc_pkg::item_t           q_push_data
);
    import bvtc_pkg::*;

    logic mux_level_reg;
    logic mux_level_next;
    logic volt_sel_reg;
    logic volt_sel_next;
    logic is_temp;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign q_push    = s_valid && s_ready;
    assign is_temp   = (mux_level_reg != volt_sel_reg);

    always_comb begin
        mux_level_next = q_push ? !mux_level_reg : mux_level_reg;
        volt_sel_next  = (cfg_valid && cfg_ready) ? cfg_data : volt_sel_reg;
    end

    assign q_push_data.is_temp  = is_temp;
    assign q_push_data.mux_next = !mux_level_reg;
    assign q_push_data.sample   = s_raw_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mux_level_reg <= 1'b0;
            volt_sel_reg  <= 1'b0;
        end else begin
            mux_level_reg <= mux_level_next;
            volt_sel_reg  <= volt_sel_next;
        end
    end

endmodule

[rtl/bvtc_queue.sv]
// ----------------------------------------------------------------------------
// bvtc_queue
// Two-entry queue that decouples sample acceptance from the conversion
// pipeline.
// ----------------------------------------------------------------------------
module bvtc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bvtc_pkg::item_t push_data,
    output logic            full,
    input  logic            pop,
    output bvtc_pkg::item_t pop_data,
    output logic            empty
);
    import bvtc_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/bvtc_back.sv]
// ----------------------------------------------------------------------------
// bvtc_back
// Three-stage conversion pipeline: millivolts and charge for the battery
// channel, piecewise-linear temperature for the thermistor channel, and the
// held readings that form each result word.
// ----------------------------------------------------------------------------
module bvtc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bvtc_pkg::item_t                   q_data,
    input  logic                              q_empty,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_channel_read,
    output logic                              m_mux_next,
    output logic [bvtc_pkg::MV_W-1:0]         m_voltage_mv,
    output logic [bvtc_pkg::CHG_W-1:0]        m_charge_percent,
    output logic signed [bvtc_pkg::TEMP_W-1:0] m_temperature_deg
);
    import bvtc_pkg::*;

    logic advance;

    logic                      s1_valid_reg;
    logic                      s1_is_temp_reg;
    logic                      s1_mux_reg;
    logic [VPROD_W-1:0]        s1_vprod_reg;
    logic signed [BASE_W-1:0]  s1_base_reg;
    logic signed [SPROD_W-1:0] s1_sprod_reg;

    logic                      s2_valid_reg;
    logic                      s2_is_temp_reg;
    logic                      s2_mux_reg;
    logic [MV_W-1:0]           s2_mv_reg;
    logic signed [TEMP_W-1:0]  s2_temp_reg;

    logic                      out_valid_reg;
    logic                      chan_reg;
    logic                      mux_next_reg;
    logic [MV_W-1:0]           held_voltage_reg;
    logic [CHG_W-1:0]          held_charge_reg;
    logic signed [TEMP_W-1:0]  held_temp_reg;

    logic [SEG_IDX_BITS-1:0]   seg_idx;
    logic [SEGMENT_BITS-1:0]   seg_off;
    logic [VQ_W-1:0]           volt_q;
    logic [MV_W-1:0]           mv_value;
    logic signed [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]          acc_mag;
    logic [TEMP_W-1:0]         deg_mag;
    logic [TEMP_W-1:0]         temp_value;
    logic                      below_base;
    logic [SOC_DIFF_W-1:0]     soc_diff;
    logic [SOC_PROD_W-1:0]     soc_prod;
    logic [SOC_Q_W-1:0]        soc_q;
    logic [CHG_W-1:0]          charge_value;

    assign advance = !out_valid_reg || m_ready;
    assign q_pop   = advance && !q_empty;

    assign seg_idx = q_data.sample[SAMPLE_BITS-1:SEGMENT_BITS];
    assign seg_off = q_data.sample[SEGMENT_BITS-1:0];

    always_comb begin
        volt_q   = VQ_W'(s1_vprod_reg) * VQ_W'(VOLT_RECIP);
        mv_value = volt_q[VOLT_SHIFT +: MV_W];

        acc        = ACC_W'(s1_base_reg) + ACC_W'(s1_sprod_reg);
        acc_mag    = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        deg_mag    = acc_mag[FRAC_BITS +: TEMP_W];
        temp_value = acc[ACC_W-1] ? TEMP_W'(-deg_mag) : deg_mag;

        below_base   = (s2_mv_reg < MV_W'(SOC_BASE_MV));
        soc_diff     = SOC_DIFF_W'(s2_mv_reg - MV_W'(SOC_BASE_MV));
        soc_prod     = SOC_PROD_W'(soc_diff) * SOC_PROD_W'(SOC_RECIP);
        soc_q        = soc_prod[SOC_SHIFT +: SOC_Q_W];
        charge_value = below_base ? '0
                     : ((soc_q > SOC_Q_W'(255)) ? 8'd255 : soc_q[CHG_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_is_temp_reg <= q_data.is_temp;
            s1_mux_reg     <= q_data.mux_next;
            s1_vprod_reg   <= VPROD_W'(q_data.sample) * VPROD_W'(VOLT_MUL);
            s1_base_reg    <= seg_base(seg_idx);
            s1_sprod_reg   <= SPROD_W'(seg_slope(seg_idx)) * $signed({1'b0, seg_off});
            s2_is_temp_reg <= s1_is_temp_reg;
            s2_mux_reg     <= s1_mux_reg;
            s2_mv_reg      <= mv_value;
            s2_temp_reg    <= temp_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            chan_reg         <= 1'b0;
            mux_next_reg     <= 1'b0;
            held_voltage_reg <= '0;
            held_charge_reg  <= 8'd255;
            held_temp_reg    <= '0;
        end else if (advance) begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg) begin
                chan_reg     <= s2_is_temp_reg;
                mux_next_reg <= s2_mux_reg;
                if (s2_is_temp_reg) begin
                    held_temp_reg <= s2_temp_reg;
                end else begin
                    held_voltage_reg <= s2_mv_reg;
                    held_charge_reg  <= charge_value;
                end
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_channel_read    = chan_reg;
    assign m_mux_next        = mux_next_reg;
    assign m_voltage_mv      = held_voltage_reg;
    assign m_charge_percent  = held_charge_reg;
    assign m_temperature_deg = held_temp_reg;

endmodule

[rtl/bvtc_checker.sv]
// ----------------------------------------------------------------------------
// bvtc_checker
// Port-level checks on the converter's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "battery_voltage_temp_adc_converter_macros.svh"

module bvtc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_channel_read,
    input logic                                m_mux_next,
    input logic [bvtc_pkg::MV_W-1:0]           m_voltage_mv,
    input logic [bvtc_pkg::CHG_W-1:0]          m_charge_percent,
    input logic signed [bvtc_pkg::TEMP_W-1:0]  m_temperature_deg
);
    import bvtc_pkg::*;

    `BVTC_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !m_valid, "result word valid after reset")

    `BVTC_ASSERT(a_held_when_stalled, m_valid && !m_ready |=> m_valid && $stable(m_voltage_mv) && $stable(m_temperature_deg) && $stable(m_channel_read) && $stable(m_mux_next), "stalled result word changed")

    `BVTC_ASSERT(a_temp_range, m_valid |-> m_temperature_deg >= -9'sd3 && m_temperature_deg <= 9'sd180, "temperature out of range")

    `BVTC_ASSERT(a_charge_low_voltage, m_valid && m_voltage_mv < 13'd3000 |-> m_charge_percent == 8'd0 || m_charge_percent == 8'd255, "charge nonzero below base voltage")

endmodule

bind battery_voltage_temp_adc_converter bvtc_checker u_checker (.*);
